// ----- hdl/random_segment_drift_generator_defines.svh -----
// ----------------------------------------------------------------------------
// Random segment drift generator - assertion macros
// Shared concurrent-check templates for the drift generator RTL.
// ----------------------------------------------------------------------------
`ifndef RANDOM_SEGMENT_DRIFT_GENERATOR_DEFINES_SVH
`define RANDOM_SEGMENT_DRIFT_GENERATOR_DEFINES_SVH

// Same-cycle implication, masked while reset is applied.
`define RSDG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is applied.
`define RSDG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rsdg_pkg.sv -----
// ----------------------------------------------------------------------------
// rsdg_pkg
// Widths, reset values and shared types of the random segment drift generator.
// ----------------------------------------------------------------------------
package rsdg_pkg;

    localparam int SAMPLE_RATE_DEF = 48000;

    localparam int FREQ_W     = 14;
    localparam int GAIN_W     = 16;
    localparam int RND_W      = 16;
    localparam int LVL_W      = 16;
    localparam int LEN_W      = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Shared divider: 33-bit dividend covers the rounded slope numerator.
    localparam int DVD_W = 33;
    localparam int DSR_W = LEN_W;
    localparam int CNT_W = 6;

    // Slope in Q16: sign plus 33-bit magnitude.
    localparam int SLP_W = DVD_W + 1;

    localparam logic [FREQ_W-1:0] MAX_FREQ_RST = FREQ_W'(64);
    localparam logic [FREQ_W-1:0] MIN_FREQ_RST = FREQ_W'(32);
    localparam logic [GAIN_W-1:0] OUT_GAIN_RST = GAIN_W'(328);

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_FREQ = 2'd0,
        CFG_MIN_FREQ = 2'd1,
        CFG_OUT_GAIN = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- hdl/rsdg_divider.sv -----
// ----------------------------------------------------------------------------
// rsdg_divider
// Restoring serial divider, one quotient bit per cycle, shared by all divides.
// ----------------------------------------------------------------------------
module rsdg_divider
    import rsdg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    input  logic [CNT_W-1:0] steps,
    output div_stat_t        stat,
    output logic [DVD_W-1:0] quotient
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVD_W-1:0] quo_reg, quo_next;

    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   trial_sub;
    logic             trial_ge;

    assign trial     = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};
    assign trial_ge  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            rem_next  = '0;
            dsr_next  = divisor;
            dvd_next  = dividend;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the low bits hold it
            rem_next = trial_ge ? trial_sub[DSR_W-1:0] : trial[DSR_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], trial_ge};
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ----- hdl/random_segment_drift_generator.sv -----
// A tick inside a segment runs S_SMP_MUL, S_SMP_GAIN and S_SMP_OUT, where it waits
// for room in the output register. A tick that opens a segment first runs two
// length-bound divides and one slope divide on the shared divider.
// One item at a time: the input stalls until the sequencer is back in idle.
// Reset (async, active low): state and config registers to defaults, a new segment
// from level 0 is pending; working registers are not reset; no clearing pass.
// ----------------------------------------------------------------------------
// random_segment_drift_generator
// Drift waveform of straight segments between random levels, sampled per tick,
// with slope and length bounds computed on one shared serial divider.
// ----------------------------------------------------------------------------
`include "random_segment_drift_generator_defines.svh"

module random_segment_drift_generator
    import rsdg_pkg::*;
#(
    parameter int SAMPLE_RATE = SAMPLE_RATE_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration write port
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    op,
    input  logic [RND_W-1:0]        rand_length,
    input  logic [RND_W-1:0]        rand_level,
    // output channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [LVL_W-1:0] sample,
    output logic                    segment_start
);

    // Length bound numerator 8*SAMPLE_RATE, left-aligned in the divider so
    // only BND_W quotient steps are needed.
    localparam int BND_NUM = 8 * SAMPLE_RATE;
    localparam int BND_W   = $clog2(BND_NUM + 1);
    localparam logic [DVD_W-1:0] BND_DVD = DVD_W'(BND_NUM) << (DVD_W - BND_W);

    localparam int ACC_W = SLP_W + LEN_W + 1;   // slope * position product
    localparam int GP_W  = LVL_W + GAIN_W + 1;  // level * gain product
    localparam int MUL_W = LEN_W + RND_W;       // span * rand_length

    localparam logic signed [ACC_W-1:0] LVL_HI  = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] LVL_LO  = ACC_W'(-32768);
    localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(32768);
    localparam logic signed [GP_W-1:0]  SMP_HI  = GP_W'(32767);
    localparam logic signed [GP_W-1:0]  SMP_LO  = GP_W'(-32768);
    localparam logic signed [GP_W-1:0]  GP_RND  = GP_W'(16384);

    // Sequencer, one-hot
    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_BND_A    = 10'b0000000010,  // divide for max_freq bound
        S_BND_B    = 10'b0000000100,  // divide for min_freq bound
        S_LEN_MUL  = 10'b0000001000,  // span * rand_length
        S_LEN_SUM  = 10'b0000010000,  // length, levels, position reset
        S_SLP_GO   = 10'b0000100000,  // launch slope divide
        S_SLP_RUN  = 10'b0001000000,  // wait for slope quotient
        S_SMP_MUL  = 10'b0010000000,  // slope * position
        S_SMP_GAIN = 10'b0100000000,  // level clamp, level * gain
        S_SMP_OUT  = 10'b1000000000   // saturate into output register
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [FREQ_W-1:0] max_freq_reg, max_freq_next;
    logic [FREQ_W-1:0] min_freq_reg, min_freq_next;
    logic [GAIN_W-1:0] out_gain_reg, out_gain_next;

    // architectural segment state
    logic [LEN_W-1:0]        position_reg, position_next;
    logic [LEN_W-1:0]        seg_len_reg, seg_len_next;
    logic signed [LVL_W-1:0] start_level_reg, start_level_next;
    logic signed [LVL_W-1:0] end_level_reg, end_level_next;
    logic signed [SLP_W-1:0] slope_reg, slope_next;
    logic                    seg_pending_reg, seg_pending_next;

    // item and working registers
    logic                    op_reg, op_next;
    logic [RND_W-1:0]        rlen_reg, rlen_next;
    logic [RND_W-1:0]        rlvl_reg, rlvl_next;
    logic [LEN_W-1:0]        bnd_a_reg, bnd_a_next;
    logic [LEN_W-1:0]        lo_reg, lo_next;
    logic [LEN_W-1:0]        span_reg, span_next;
    logic [MUL_W-1:0]        len_prod_reg, len_prod_next;
    logic                    neg_reg, neg_next;
    logic signed [ACC_W-1:0] lvl_prod_reg, lvl_prod_next;
    logic signed [GP_W-1:0]  gain_prod_reg, gain_prod_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic signed [LVL_W-1:0] sample_reg, sample_next;
    logic                    seg_start_reg, seg_start_next;

    // shared divider
    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DSR_W-1:0] div_dsr;
    logic [CNT_W-1:0] div_steps;
    div_stat_t        div_stat;
    logic [DVD_W-1:0] div_quo;

    // combinational helpers
    logic                    in_xfer;
    logic                    out_free;
    logic [LEN_W-1:0]        bnd_q;
    logic [DSR_W-1:0]        fmax_dsr;
    logic [DSR_W-1:0]        fmin_dsr;
    logic [LEN_W-1:0]        seg_len_calc;
    logic signed [LVL_W:0]   lvl_diff;
    logic [LVL_W:0]          lvl_mag;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] level_full;
    logic signed [LVL_W-1:0] level_sat;
    logic signed [GP_W-1:0]  gain_sum;
    logic signed [GP_W-1:0]  smp_full;
    logic [LEN_W-1:0]        position_inc;

    rsdg_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .steps    (div_steps),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    // output register can take a new sample if empty or being drained
    assign out_free = !out_valid_reg || !out_stall;

    // zero frequency counts as one
    assign fmax_dsr = (max_freq_reg == '0) ? DSR_W'(1) : DSR_W'(max_freq_reg);
    assign fmin_dsr = (min_freq_reg == '0) ? DSR_W'(1) : DSR_W'(min_freq_reg);

    // bound clamp to [1, LEN_MAX]
    always_comb
    begin
        if (div_quo == '0)
            bnd_q = LEN_W'(1);
        else if (div_quo > DVD_W'(LEN_MAX))
            bnd_q = LEN_MAX;
        else
            bnd_q = div_quo[LEN_W-1:0];
    end

    assign seg_len_calc = lo_reg + len_prod_reg[MUL_W-1:RND_W];

    assign lvl_diff = $signed({end_level_reg[LVL_W-1], end_level_reg})
                    - $signed({start_level_reg[LVL_W-1], start_level_reg});
    assign lvl_mag  = lvl_diff[LVL_W] ? (LVL_W+1)'(-lvl_diff) : lvl_diff;

    assign acc        = (ACC_W'(start_level_reg) <<< 16) + lvl_prod_reg + ACC_RND;
    assign level_full = acc >>> 16;

    always_comb
    begin
        if (level_full > LVL_HI)
            level_sat = LVL_W'(32767);
        else if (level_full < LVL_LO)
            level_sat = LVL_W'(-32768);
        else
            level_sat = level_full[LVL_W-1:0];
    end

    assign gain_sum = gain_prod_reg + GP_RND;
    assign smp_full = gain_sum >>> 15;

    assign position_inc = position_reg + LEN_W'(1);

    // divider launch: bounds in idle / after first bound, slope in its own step
    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = BND_DVD;
        div_dsr   = fmax_dsr;
        div_steps = CNT_W'(BND_W);
        case (state_reg)
            S_IDLE:
            begin
                div_start = in_xfer && ((op == OP_RESTART) || seg_pending_reg);
            end
            S_BND_A:
            begin
                div_start = div_stat.done;
                div_dsr   = fmin_dsr;
            end
            S_SLP_GO:
            begin
                div_start = 1'b1;
                // |diff| * 2^16 + length/2: round half away from zero
                div_dvd   = DVD_W'({lvl_mag[LVL_W-1:0], 16'h0000})
                          + DVD_W'(seg_len_reg[LEN_W-1:1]);
                div_dsr   = seg_len_reg;
                div_steps = CNT_W'(DVD_W);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        max_freq_next    = max_freq_reg;
        min_freq_next    = min_freq_reg;
        out_gain_next    = out_gain_reg;
        position_next    = position_reg;
        seg_len_next     = seg_len_reg;
        start_level_next = start_level_reg;
        end_level_next   = end_level_reg;
        slope_next       = slope_reg;
        seg_pending_next = seg_pending_reg;
        op_next          = op_reg;
        rlen_next        = rlen_reg;
        rlvl_next        = rlvl_reg;
        bnd_a_next       = bnd_a_reg;
        lo_next          = lo_reg;
        span_next        = span_reg;
        len_prod_next    = len_prod_reg;
        neg_next         = neg_reg;
        lvl_prod_next    = lvl_prod_reg;
        gain_prod_next   = gain_prod_reg;
        out_valid_next   = out_valid_reg;
        sample_next      = sample_reg;
        seg_start_next   = seg_start_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MAX_FREQ: max_freq_next = cfg_data[FREQ_W-1:0];
                CFG_MIN_FREQ: min_freq_next = cfg_data[FREQ_W-1:0];
                CFG_OUT_GAIN: out_gain_next = cfg_data[GAIN_W-1:0];
                default:      max_freq_next = max_freq_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next   = op;
                    rlen_next = rand_length;
                    rlvl_next = rand_level;
                    if (op == OP_RESTART)
                    begin
                        end_level_next = '0;
                        state_next     = S_BND_A;
                    end
                    else if (seg_pending_reg)
                        state_next = S_BND_A;
                    else
                        state_next = S_SMP_MUL;
                end
            end
            S_BND_A:
            begin
                if (div_stat.done)
                begin
                    bnd_a_next = bnd_q;
                    state_next = S_BND_B;
                end
            end
            S_BND_B:
            begin
                if (div_stat.done)
                begin
                    if (bnd_a_reg < bnd_q)
                    begin
                        lo_next   = bnd_a_reg;
                        span_next = bnd_q - bnd_a_reg;
                    end
                    else
                    begin
                        lo_next   = bnd_q;
                        span_next = bnd_a_reg - bnd_q;
                    end
                    state_next = S_LEN_MUL;
                end
            end
            S_LEN_MUL:
            begin
                len_prod_next = span_reg * rlen_reg;
                state_next    = S_LEN_SUM;
            end
            S_LEN_SUM:
            begin
                seg_len_next     = (seg_len_calc == '0) ? LEN_W'(1) : seg_len_calc;
                position_next    = '0;
                start_level_next = end_level_reg;
                // rand_level - 32768 is a flip of the top bit
                end_level_next   = {~rlvl_reg[RND_W-1], rlvl_reg[RND_W-2:0]};
                seg_pending_next = 1'b0;
                state_next       = S_SLP_GO;
            end
            S_SLP_GO:
            begin
                neg_next   = lvl_diff[LVL_W];
                state_next = S_SLP_RUN;
            end
            S_SLP_RUN:
            begin
                if (div_stat.done)
                begin
                    slope_next = neg_reg ? -SLP_W'(div_quo) : SLP_W'(div_quo);
                    state_next = (op_reg == OP_RESTART) ? S_IDLE : S_SMP_MUL;
                end
            end
            S_SMP_MUL:
            begin
                lvl_prod_next = slope_reg * $signed({1'b0, position_reg});
                state_next    = S_SMP_GAIN;
            end
            S_SMP_GAIN:
            begin
                gain_prod_next = level_sat * $signed({1'b0, out_gain_reg});
                state_next     = S_SMP_OUT;
            end
            S_SMP_OUT:
            begin
                if (out_free)
                begin
                    if (smp_full > SMP_HI)
                        sample_next = LVL_W'(32767);
                    else if (smp_full < SMP_LO)
                        sample_next = LVL_W'(-32768);
                    else
                        sample_next = smp_full[LVL_W-1:0];
                    seg_start_next   = (position_reg == '0);
                    out_valid_next   = 1'b1;
                    position_next    = position_inc;
                    seg_pending_next = (position_inc >= seg_len_reg);
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            max_freq_reg    <= MAX_FREQ_RST;
            min_freq_reg    <= MIN_FREQ_RST;
            out_gain_reg    <= OUT_GAIN_RST;
            position_reg    <= '0;
            seg_len_reg     <= '0;
            start_level_reg <= '0;
            end_level_reg   <= '0;
            slope_reg       <= '0;
            seg_pending_reg <= 1'b1;
            op_reg          <= OP_TICK;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            max_freq_reg    <= max_freq_next;
            min_freq_reg    <= min_freq_next;
            out_gain_reg    <= out_gain_next;
            position_reg    <= position_next;
            seg_len_reg     <= seg_len_next;
            start_level_reg <= start_level_next;
            end_level_reg   <= end_level_next;
            slope_reg       <= slope_next;
            seg_pending_reg <= seg_pending_next;
            op_reg          <= op_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rlen_reg      <= rlen_next;
        rlvl_reg      <= rlvl_next;
        bnd_a_reg     <= bnd_a_next;
        lo_reg        <= lo_next;
        span_reg      <= span_next;
        len_prod_reg  <= len_prod_next;
        neg_reg       <= neg_next;
        lvl_prod_reg  <= lvl_prod_next;
        gain_prod_reg <= gain_prod_next;
        sample_reg    <= sample_next;
        seg_start_reg <= seg_start_next;
    end

    assign out_valid     = out_valid_reg;
    assign sample        = sample_reg;
    assign segment_start = seg_start_reg;

    // divider only finishes while the sequencer waits on it
    `RSDG_ASSERT_NOW(a_div_done_owned, clk, rst_n, div_stat.done,
        (state_reg == S_BND_A || state_reg == S_BND_B || state_reg == S_SLP_RUN),
        "divider done outside a wait step")

    // an open segment always has position inside its length
    `RSDG_ASSERT_NOW(a_pos_in_segment, clk, rst_n, !seg_pending_reg,
        (position_reg < seg_len_reg), "position ran past segment length")

    // a finished sample lands in the output register and frees the input
    `RSDG_ASSERT_NEXT(a_sample_delivered, clk, rst_n,
        (state_reg == S_SMP_OUT && out_free),
        (out_valid_reg && state_reg == S_IDLE), "sample not registered")

endmodule

// ----- tb/rsdg_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsdg_checker
// Passive checker for the drift generator: shadows the register port, predicts
// each sample from the accepted input transfers and compares output transfers.
// ----------------------------------------------------------------------------
module rsdg_checker
    import rsdg_pkg::*;
#(
    parameter int SAMPLE_RATE = SAMPLE_RATE_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    op,
    input  logic [RND_W-1:0]        rand_length,
    input  logic [RND_W-1:0]        rand_level,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [LVL_W-1:0] sample,
    input  logic                    segment_start,
    output int                      mismatches,
    output int                      outstanding,
    output int                      samples_seen,
    output int                      segments_opened,
    output int                      restarts_seen,
    output int                      clipped
);

    localparam int SLOPE_W = 40;

    typedef struct packed {
        logic signed [LVL_W-1:0] sample;
        logic                    seg_first;
    } drift_out_t;

    logic [FREQ_W-1:0]         max_freq_r;
    logic [FREQ_W-1:0]         min_freq_r;
    logic [GAIN_W-1:0]         gain_r;

    logic [LEN_W-1:0]          pos;
    logic [LEN_W-1:0]          seg_len;
    logic signed [LVL_W-1:0]   lvl_start;
    logic signed [LVL_W-1:0]   lvl_end;
    logic signed [SLOPE_W-1:0] slope_q16;
    logic                      seg_pending;

    drift_out_t pending_samples[$];
    int n_err, n_samples, n_segments, n_restarts, n_clipped;

    // floor(8*fs/f), zero frequency counts as 1, clamped to the length range
    function automatic int unsigned len_bound(input logic [FREQ_W-1:0] f);
        int unsigned d;
        int unsigned q;
        d = (f == '0) ? 1 : int'(f);
        q = (8 * SAMPLE_RATE) / d;
        if (q < 1)
            q = 1;
        if (q > 32'(LEN_MAX))
            q = 32'(LEN_MAX);
        return q;
    endfunction

    function automatic void open_segment(input logic [RND_W-1:0] rl,
                                         input logic [RND_W-1:0] rv);
        int unsigned a, b, lo, hi, len;
        longint      span, num, mag, q;
        a  = len_bound(max_freq_r);
        b  = len_bound(min_freq_r);
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        span = longint'(hi - lo) * longint'(rl);
        len  = lo + 32'(span >> 16);
        if (len < 1)
            len = 1;
        seg_len   = LEN_W'(len);
        pos       = '0;
        lvl_start = lvl_end;
        lvl_end   = $signed(rv ^ 16'h8000);
        // rounded divide, ties away from zero
        num = (longint'(lvl_end) - longint'(lvl_start)) * 65536;
        mag = (num < 0) ? -num : num;
        q   = (mag + longint'(len / 2)) / longint'(len);
        slope_q16   = SLOPE_W'((num < 0) ? -q : q);
        seg_pending = 1'b0;
        n_segments++;
    endfunction

    function automatic drift_out_t drift_tick(input logic [RND_W-1:0] rl,
                                              input logic [RND_W-1:0] rv);
        drift_out_t res;
        longint     acc, lvl, s;
        if (seg_pending)
            open_segment(rl, rv);
        acc = longint'(lvl_start) * 65536 + longint'(slope_q16) * longint'(pos) + 32768;
        lvl = acc >>> 16;
        if (lvl > 32767)
            lvl = 32767;
        else if (lvl < -32768)
            lvl = -32768;
        s = (lvl * longint'(gain_r) + 16384) >>> 15;
        if (s > 32767)
        begin
            s = 32767;
            n_clipped++;
        end
        else if (s < -32768)
        begin
            s = -32768;
            n_clipped++;
        end
        res.sample    = LVL_W'(s);
        res.seg_first = (pos == '0);
        pos = pos + 1'b1;
        if (pos >= seg_len)
            seg_pending = 1'b1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        drift_out_t want;
        if (!rst_n)
        begin
            max_freq_r  = MAX_FREQ_RST;
            min_freq_r  = MIN_FREQ_RST;
            gain_r      = OUT_GAIN_RST;
            pos         = '0;
            seg_len     = '0;
            lvl_start   = '0;
            lvl_end     = '0;
            slope_q16   = '0;
            seg_pending = 1'b1;
            pending_samples.delete();
            n_err      = 0;
            n_samples  = 0;
            n_segments = 0;
            n_restarts = 0;
            n_clipped  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_FREQ: max_freq_r = cfg_data[FREQ_W-1:0];
                    CFG_MIN_FREQ: min_freq_r = cfg_data[FREQ_W-1:0];
                    CFG_OUT_GAIN: gain_r     = cfg_data[GAIN_W-1:0];
                    default:      ;
                endcase
            end

            // output side first: a sample can never belong to a same-edge input
            if (out_valid && !out_stall)
            begin
                if (pending_samples.size() == 0)
                begin
                    $error("unexpected output transfer: sample %0d, segment_start %0b",
                           sample, segment_start);
                    n_err++;
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (sample !== want.sample)
                    begin
                        $error("sample: expected %0d, got %0d", want.sample, sample);
                        n_err++;
                    end
                    if (segment_start !== want.seg_first)
                    begin
                        $error("segment_start: expected %0b, got %0b",
                               want.seg_first, segment_start);
                        n_err++;
                    end
                    n_samples++;
                end
            end

            if (in_valid && !in_stall)
            begin
                if (op == OP_RESTART)
                begin
                    lvl_end = '0;
                    open_segment(rand_length, rand_level);
                    n_restarts++;
                end
                else
                    pending_samples.push_back(drift_tick(rand_length, rand_level));
            end
        end
        mismatches      <= n_err;
        outstanding     <= pending_samples.size();
        samples_seen    <= n_samples;
        segments_opened <= n_segments;
        restarts_seen   <= n_restarts;
        clipped         <= n_clipped;
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the random segment drift generator: directed corner
// items, then randomly programmed phases with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top
    import rsdg_pkg::*;
();

    // Watchdog limit on cycles without any transfer. The longest quiet stretch
    // in a correct run is the receiver hold-off (HOLD_CYCLES) plus one segment
    // open, so this leaves a wide margin.
    localparam int LIMIT       = 4000;
    localparam int HOLD_CYCLES = 400;
    // Pause after the last sample before a register write; a restart has no
    // sample of its own but keeps the divider busy through its bound and slope divides.
    localparam int SETTLE      = 150;
    localparam int DRAIN       = 150;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 80;

    // register index with no register behind it; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    op;
    logic [RND_W-1:0]        rand_length;
    logic [RND_W-1:0]        rand_level;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [LVL_W-1:0] sample;
    logic                    segment_start;

    int mismatches, outstanding, samples_seen, segments_opened, restarts_seen, clipped;
    int programs = 0;

    // quiet: no idling on either side (final phase)
    // hold_req: ask the receiver for one long hold-off
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;

    random_segment_drift_generator #(
        .SAMPLE_RATE   (SAMPLE_RATE_DEF)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .rand_length   (rand_length),
        .rand_level    (rand_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample        (sample),
        .segment_start (segment_start)
    );

    rsdg_checker #(
        .SAMPLE_RATE     (SAMPLE_RATE_DEF)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .rand_length     (rand_length),
        .rand_level      (rand_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sample          (sample),
        .segment_start   (segment_start),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .samples_seen    (samples_seen),
        .segments_opened (segments_opened),
        .restarts_seen   (restarts_seen),
        .clipped         (clipped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random word, with the edges of the level range mixed in.
    function automatic logic [RND_W-1:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return RND_W'($urandom);
        endcase
    endfunction

    // Frequencies lean high so segments stay short (23..48 samples) and many
    // segment opens happen; sometimes the full range, sometimes a raw 16-bit
    // word whose upper bits the block must drop.
    function automatic logic [CFG_DATA_W-1:0] pick_freq();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return CFG_DATA_W'($urandom_range(8000, 16383));
        if (r < 8)
            return CFG_DATA_W'($urandom_range(1500, 16383));
        if (r == 8)
            return CFG_DATA_W'($urandom_range(0, 16383));
        return CFG_DATA_W'($urandom);
    endfunction

    // One transfer on the input channel. Valid stays high from one item to the
    // next unless a random gap is taken, so it is never lowered and raised in
    // the same step.
    task automatic offer(input logic o, input logic [RND_W-1:0] rl,
                         input logic [RND_W-1:0] rv);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        rand_length <= rl;
        rand_level  <= rv;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid, wait for every predicted sample, then let the divider finish
    // whatever a trailing restart started.
    task automatic wait_drained(input int extra);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (extra) @(posedge clk);
    endtask

    // Back-to-back register writes; optionally a write to the unused index.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] max_f,
                                input logic [CFG_DATA_W-1:0] min_f,
                                input logic [CFG_DATA_W-1:0] gain,
                                input bit                    spare);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_FREQ;
        cfg_data  <= max_f;
        @(posedge clk);
        cfg_index <= CFG_MIN_FREQ;
        cfg_data  <= min_f;
        @(posedge clk);
        cfg_index <= CFG_OUT_GAIN;
        cfg_data  <= gain;
        @(posedge clk);
        if (spare)
        begin
            cfg_index <= CFG_SPARE;
            cfg_data  <= '1;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        programs++;
    endtask

    // Receiver: random stall bursts, one long hold-off on request, none at the end.
    initial
    begin : receiver
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Watchdog: ends the run as a fail once transfers stop on both channels.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic                  o;
        logic [CFG_DATA_W-1:0] g;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        op          <= OP_TICK;
        rand_length <= '0;
        rand_level  <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_MAX_FREQ;
        cfg_data    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        // Reset settings: the first tick opens a segment from level zero;
        // lowest and highest words; restart then tick.
        offer(OP_TICK,    16'h0000, 16'h0000);
        offer(OP_TICK,    16'hFFFF, 16'hFFFF);
        offer(OP_RESTART, 16'hFFFF, 16'hFFFF);
        offer(OP_TICK,    16'h0000, 16'h8000);

        // Zero min frequency (taken as 1), highest max frequency, full gain.
        // Shortest possible segment towards full scale, then the longest.
        wait_drained(SETTLE);
        program_regs(16'd16383, 16'd0, 16'hFFFF, 1'b0);
        offer(OP_RESTART, 16'h0000, 16'hFFFF);
        offer(OP_TICK,    16'h1234, 16'h0000);
        offer(OP_TICK,    16'hFFFF, 16'hFFFF);
        offer(OP_TICK,    16'h0000, 16'h0000);
        offer(OP_RESTART, 16'hFFFF, 16'h0000);
        offer(OP_TICK,    16'h0000, 16'hFFFF);

        // Swapped bounds (min above max), unity gain, write to the unused
        // index; a flat segment, then a restart ending just below zero.
        wait_drained(SETTLE);
        program_regs(16'd100, 16'd16383, 16'h8000, 1'b1);
        offer(OP_RESTART, 16'h0000, 16'h8000);
        offer(OP_TICK,    16'h0000, 16'h0000);
        offer(OP_TICK,    16'hFFFF, 16'h0000);
        offer(OP_RESTART, 16'h8000, 16'h7FFF);
        offer(OP_TICK,    16'hFFFF, 16'hFFFF);

        // All-ones writes: upper bits dropped, equal bounds, zero gain.
        wait_drained(SETTLE);
        program_regs(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        offer(OP_RESTART, 16'hFFFF, 16'hFFFF);
        offer(OP_TICK,    16'h0000, 16'h0000);
        offer(OP_TICK,    16'hFFFF, 16'h0000);
        offer(OP_TICK,    16'h5555, 16'hAAAA);

        // --- random part ---
        // Each phase reprograms while idle; mostly ticks, a few restarts.
        // Phase 3 gets the long receiver hold-off; the last phase runs with
        // no idling at all.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_drained(SETTLE);
            case ($urandom_range(0, 7))
                0:       g = '0;
                1:       g = '1;
                2:       g = 16'h8000;
                default: g = CFG_DATA_W'($urandom);
            endcase
            program_regs(pick_freq(), pick_freq(), g, $urandom_range(0, 3) == 0);
            if (ph == RAND_PHASES - 1)
                quiet = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 3 && i == 20)
                    hold_req = 1'b1;
                o = ($urandom_range(0, 19) == 0) ? OP_RESTART : OP_TICK;
                offer(o, pick_word(), pick_word());
            end
        end

        wait_drained(DRAIN);

        $display("Checked %0d samples over %0d segments, %0d restarts, %0d saturated",
                 samples_seen, segments_opened, restarts_seen, clipped);
        $display("%0d register settings, with clipped widths, swapped and zero bounds",
                 programs);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/rsdg_pkg.sv
hdl/rsdg_divider.sv
hdl/random_segment_drift_generator.sv
tb/rsdg_checker.sv
tb/tb_top.sv
